@@ design/ctss_pkg.sv @@
// ----------------------------------------------------------------------------
// Clip/translate state stack package
// Shared types and constants for the drawing-state engine: command and status
// codes, the request and result items, and the saved-state layout.
// ----------------------------------------------------------------------------
package ctss_pkg;

  // Pixel coordinates and screen dimensions.
  localparam int DIM_W = 13;
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] RESET_WIDTH = 13'd320;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd240;

  // Save/restore stack.
  localparam int STACK_DEPTH = 8;
  localparam int LEVEL_W = 4;
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  // Clip arithmetic: coordinate plus offset plus size in exact signed form.
  localparam int CLIP_W = 34;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    REQ_BEGIN_FRAME = 3'd0,
    REQ_END_FRAME   = 3'd1,
    REQ_SAVE        = 3'd2,
    REQ_RESTORE     = 3'd3,
    REQ_TRANSLATE   = 3'd4,
    REQ_CLIP        = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_INVALID_ARG   = 2'd1,
    ST_INVALID_STATE = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] arg_w;
    logic signed [31:0] arg_h;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] offset_x_out;
    logic signed [31:0] offset_y_out;
    logic [DIM_W-1:0]   clip_left;
    logic [DIM_W-1:0]   clip_top;
    logic [DIM_W-1:0]   clip_right;
    logic [DIM_W-1:0]   clip_bottom;
    logic [LEVEL_W-1:0] stack_level;
    logic               in_frame;
  } rsp_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] bottom;
  } box_t;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    box_t               box;
  } draw_state_t;

endpackage

@@ design/clip_translate_state_stack_core.sv @@
// ----------------------------------------------------------------------------
// Clip/translate state stack core
// Drawing-state engine of a 2D raster unit: translation, clip rectangle
// clamped to the screen, and a save/restore stack of drawing states.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the req channel (req_valid/req_ready, payload req) and
// each one produces exactly one result item on the rsp channel
// (rsp_valid/rsp_ready, payload rsp): a status plus the drawing state as it
// stands after the command.
// An accepted item first lands in a command register. From there it is
// executed against the drawing state once the result register is free or
// being emptied, and its result is written to the result register, which
// raises rsp_valid. One item is taken every cycle while the receiver keeps
// up; the single execute step (an adder and a few compares per clip edge)
// sets that rate.
// When the receiver stalls, the result register holds its item, the command
// register holds the next one, and req_ready drops once both are full.
// The stack lives in a small memory with a registered read port that always
// holds the top entry, so restore reads it without waiting on the memory.
// The user writes the screen size registers through cfg_we/cfg_index/cfg_data while the
// block is idle, which the block itself does not enforce; values above MAX_DIM saturate to MAX_DIM.
// Reset clears the translation, clip box, stack level and frame flag, sets
// the screen size to 320 by 240 and empties both pipeline registers.
// ----------------------------------------------------------------------------
module clip_translate_state_stack_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_ready,
  input  ctss_pkg::req_item_t                  req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_ready,
  output ctss_pkg::rsp_item_t                  rsp,
  input  logic                                 cfg_we,
  input  logic [ctss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ctss_pkg::DIM_W-1:0]           cfg_data
);
  import ctss_pkg::*;

  // Configuration registers.
  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [DIM_W-1:0] cfg_sat;

  // Command register.
  req_item_t cmd;
  logic      cmd_valid;
  logic      advance;

  // Drawing state.
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  box_t               box;
  logic [LEVEL_W-1:0] depth;
  logic               frame_on;

  // Next values produced by the executing command.
  status_t            status_next;
  logic signed [31:0] offset_x_next;
  logic signed [31:0] offset_y_next;
  box_t               box_next;
  logic [LEVEL_W-1:0] depth_next;
  logic               frame_on_next;
  logic               push;

  // Stack memory; top_entry always mirrors the entry below depth.
  draw_state_t        stack_mem [STACK_DEPTH];
  draw_state_t        top_entry;
  draw_state_t        cur_state;
  logic [LEVEL_W-1:0] depth_eff;
  logic [ADDR_W-1:0]  rd_addr;

  // Translate arithmetic.
  logic signed [32:0] sum_x;
  logic signed [32:0] sum_y;
  logic               trans_ovf;

  // Clip arithmetic.
  logic signed [CLIP_W-1:0] x0;
  logic signed [CLIP_W-1:0] y0;
  logic signed [CLIP_W-1:0] x1;
  logic signed [CLIP_W-1:0] y1;
  logic signed [CLIP_W-1:0] wd_s;
  logic signed [CLIP_W-1:0] ht_s;
  logic signed [CLIP_W-1:0] left_s;
  logic signed [CLIP_W-1:0] top_s;
  logic signed [CLIP_W-1:0] right_s;
  logic signed [CLIP_W-1:0] bottom_s;
  logic [DIM_W-1:0]         left_c;
  logic [DIM_W-1:0]         top_c;
  logic [DIM_W-1:0]         right_c;
  logic [DIM_W-1:0]         bottom_c;
  logic                     neg_size;

  // ---------------------------------------------------------------------------
  // Handshake: a command executes when the result register is free or is
  // being emptied this cycle; the command register refills in the same edge.
  // ---------------------------------------------------------------------------
  assign advance   = cmd_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_ready) begin
      cmd_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      cmd <= req;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes, saturated to the largest supported screen.
  // ---------------------------------------------------------------------------
  assign cfg_sat = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= RESET_WIDTH;
      screen_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width <= cfg_sat;
        REG_SCREEN_HEIGHT: screen_height <= cfg_sat;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath shared by translate and clip.
  // ---------------------------------------------------------------------------
  // A translate overflows when the 33-bit sum leaves the 32-bit range.
  assign sum_x     = 33'(offset_x) + 33'(cmd.arg_x);
  assign sum_y     = 33'(offset_y) + 33'(cmd.arg_y);
  assign trans_ovf = (sum_x[32] != sum_x[31]) || (sum_y[32] != sum_y[31]);

  // The clip rectangle is moved by the translation, then intersected with
  // the current box and clamped to the screen.
  assign x0 = CLIP_W'(cmd.arg_x) + CLIP_W'(offset_x);
  assign y0 = CLIP_W'(cmd.arg_y) + CLIP_W'(offset_y);
  assign x1 = x0 + CLIP_W'(cmd.arg_w);
  assign y1 = y0 + CLIP_W'(cmd.arg_h);

  assign wd_s     = $signed({{(CLIP_W-DIM_W){1'b0}}, screen_width});
  assign ht_s     = $signed({{(CLIP_W-DIM_W){1'b0}}, screen_height});
  assign left_s   = $signed({{(CLIP_W-DIM_W){1'b0}}, box.left});
  assign top_s    = $signed({{(CLIP_W-DIM_W){1'b0}}, box.top});
  assign right_s  = $signed({{(CLIP_W-DIM_W){1'b0}}, box.right});
  assign bottom_s = $signed({{(CLIP_W-DIM_W){1'b0}}, box.bottom});

  // Near edges only move inward and stop at the screen's far edge.
  assign left_c = (x0 > left_s) ? ((x0 > wd_s) ? screen_width : x0[DIM_W-1:0]) : box.left;
  assign top_c  = (y0 > top_s) ? ((y0 > ht_s) ? screen_height : y0[DIM_W-1:0]) : box.top;

  // Far edges only move inward and stop at zero.
  assign right_c  = (x1 < right_s) ? ((x1 < 0) ? '0 : x1[DIM_W-1:0]) : box.right;
  assign bottom_c = (y1 < bottom_s) ? ((y1 < 0) ? '0 : y1[DIM_W-1:0]) : box.bottom;

  assign neg_size = cmd.arg_w[31] || cmd.arg_h[31];

  // ---------------------------------------------------------------------------
  // Command execution.
  // ---------------------------------------------------------------------------
  always_comb begin
    status_next   = ST_OK;
    offset_x_next = offset_x;
    offset_y_next = offset_y;
    box_next      = box;
    depth_next    = depth;
    frame_on_next = frame_on;
    push          = 1'b0;
    case (cmd.req_type)
      REQ_BEGIN_FRAME: begin
        if (frame_on) begin
          status_next = ST_INVALID_STATE;
        end else begin
          frame_on_next   = 1'b1;
          offset_x_next   = '0;
          offset_y_next   = '0;
          box_next.left   = '0;
          box_next.top    = '0;
          box_next.right  = screen_width;
          box_next.bottom = screen_height;
          depth_next      = '0;
        end
      end
      REQ_END_FRAME: begin
        if (!frame_on) begin
          status_next = ST_INVALID_STATE;
        end else begin
          frame_on_next = 1'b0;
        end
      end
      REQ_SAVE: begin
        if (!frame_on || depth >= LEVEL_W'(STACK_DEPTH)) begin
          status_next = ST_INVALID_STATE;
        end else begin
          push       = 1'b1;
          depth_next = depth + 1'b1;
        end
      end
      REQ_RESTORE: begin
        if (!frame_on || depth == '0) begin
          status_next = ST_INVALID_STATE;
        end else begin
          depth_next    = depth - 1'b1;
          offset_x_next = top_entry.offset_x;
          offset_y_next = top_entry.offset_y;
          box_next      = top_entry.box;
        end
      end
      REQ_TRANSLATE: begin
        if (!frame_on || trans_ovf) begin
          status_next = ST_INVALID_STATE;
        end else begin
          offset_x_next = sum_x[31:0];
          offset_y_next = sum_y[31:0];
        end
      end
      REQ_CLIP: begin
        if (neg_size) begin
          status_next = ST_INVALID_ARG;
        end else if (!frame_on) begin
          status_next = ST_INVALID_STATE;
        end else begin
          box_next.left   = left_c;
          box_next.top    = top_c;
          box_next.right  = (right_c < left_c) ? left_c : right_c;
          box_next.bottom = (bottom_c < top_c) ? top_c : bottom_c;
        end
      end
      default: begin
        status_next = ST_INVALID_ARG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      box      <= '0;
      depth    <= '0;
      frame_on <= 1'b0;
    end else if (advance) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      box      <= box_next;
      depth    <= depth_next;
      frame_on <= frame_on_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stack memory. The read port follows the level the state will have after
  // this edge, so top_entry is always the most recently saved entry. A save
  // writes exactly that address, so the written data is forwarded.
  // ---------------------------------------------------------------------------
  assign cur_state = '{offset_x: offset_x, offset_y: offset_y, box: box};
  assign depth_eff = advance ? depth_next : depth;
  assign rd_addr   = ADDR_W'(depth_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (advance && push) begin
      stack_mem[depth[ADDR_W-1:0]] <= cur_state;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      top_entry <= cur_state;
    end else begin
      top_entry <= stack_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.status       <= status_next;
      rsp.offset_x_out <= offset_x_next;
      rsp.offset_y_out <= offset_y_next;
      rsp.clip_left    <= box_next.left;
      rsp.clip_top     <= box_next.top;
      rsp.clip_right   <= box_next.right;
      rsp.clip_bottom  <= box_next.bottom;
      rsp.stack_level  <= depth_next;
      rsp.in_frame     <= frame_on_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A successful save raises the stack level by exactly one.
  a_save_level: assert property (@(posedge clk) disable iff (rst)
    advance && push |=> depth == LEVEL_W'($past(depth) + 1'b1))
    else $error("stack level did not grow by one after a save");

  // Save outside a frame is refused and leaves the stack level alone.
  a_save_outside_frame: assert property (@(posedge clk) disable iff (rst)
    advance && !frame_on && cmd.req_type == REQ_SAVE
    |=> rsp.status == ST_INVALID_STATE && depth == $past(depth))
    else $error("save outside a frame was not refused");

  // The clip box is never inverted.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    box.right >= box.left && box.bottom >= box.top)
    else $error("clip box edges crossed");

  // The stack level never exceeds the stack depth.
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.stack_level <= LEVEL_W'(STACK_DEPTH) && depth <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond stack depth");

endmodule
